@@ sv/pcbb_pkg.sv @@
// Shared types and constants for the point cloud bounding box block.
// Used by pcbb_axis, the top level and the port checker.
`default_nettype none

package pcbb_pkg;

    localparam int THRESH_W = 23;
    localparam int COUNT_W  = 21;

    localparam logic [THRESH_W-1:0] DIST_RESET = 23'd90000;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Per-axis update controls, decoded once in the top level
    typedef struct packed {
        logic clear;    // cloud starts: drop the old box first
        logic seed;     // load the point as both minimum and maximum
        logic widen;    // stretch minimum and maximum to the point
        logic mid_set;  // load the centre from the updated bounds
    } axis_ctl_t;

endpackage

`default_nettype wire

@@ sv/point_cloud_bounding_box_top.sv @@
// Top level of the streaming 3D bounding box block: input register, box
// state update and result register. Depends on pcbb_pkg and pcbb_axis.
//
//  channel | dir | handshake        | content
//  s_*     | in  | s_tvalid/s_tready | tdata: x,y,z; tuser: opcode; tlast: last point
//  m_*     | out | m_tvalid/m_tready | tdata: box, centre, count, ok, inside
//  cfg_*   | in  | cfg_we            | cfg_data: invalid_distance
//
// One transaction per cycle unless a stalled result holds the pipe; a result
// passes the input register, then is loaded into the result register, from
// which it is taken on m_*.
// The rate is set by the box state update feeding itself.
// Reset clears the box to its empty extremes and the threshold to 90000.
// A stalled result holds the pipe only for items that produce a result.
`default_nettype none

module point_cloud_bounding_box_top
    import pcbb_pkg::*;
#(
    parameter int COORD_BITS = 24,
    parameter int MAX_POINTS = 1048576
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // coord_x, coord_y, coord_z (low bits first), zero padded to bytes
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // opcode
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // low_x, low_y, low_z, high_x, high_y, high_z, mid_x, mid_y, mid_z,
    // valid_count, box_ok, inside_res (low bits first), zero padded
    output logic [((9*COORD_BITS+26+7)/8)*8-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic [THRESH_W-1:0] cfg_data
);

    localparam int C        = COORD_BITS;
    localparam int OUT_BITS = 9*C + 26;
    localparam int OUT_W    = ((OUT_BITS+7)/8)*8;
    localparam int TW       = $clog2(MAX_POINTS+1);
    localparam logic [TW-1:0] TALLY_MAX = TW'(MAX_POINTS);

    // input register
    logic                in_valid_reg;
    logic                in_op_reg;
    logic                in_last_reg;
    logic signed [C-1:0] in_coord_reg [3];

    // box state
    logic [THRESH_W-1:0] thresh_reg;
    logic signed [C-1:0] low_reg  [3];
    logic signed [C-1:0] high_reg [3];
    logic signed [C:0]   mid_reg  [3];
    logic [TW-1:0]       tally_reg;
    logic                found_reg;
    logic                open_reg;
    logic                ok_reg;

    logic signed [C-1:0] low_next  [3];
    logic signed [C-1:0] high_next [3];
    logic signed [C:0]   mid_next  [3];
    logic [TW-1:0]       tally_next;
    logic                found_next;
    logic                open_next;
    logic                ok_next;

    // result register
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg;
    logic [OUT_BITS-1:0] out_data_next;

    logic [2:0]  axis_in_range;
    logic [2:0]  axis_inside;
    axis_ctl_t   ctl;
    logic        is_add;
    logic        opening;
    logic        single;
    logic        valid_pt;
    logic        found_base;
    logic        produces;
    logic        advance;
    logic        emit;
    logic [31:0] tally_ext;

    assign is_add     = in_valid_reg && (in_op_reg == OP_ADD);
    assign opening    = is_add && !open_reg;
    assign single     = opening && in_last_reg;
    assign valid_pt   = &axis_in_range;
    assign found_base = opening ? 1'b0 : found_reg;

    always_comb
    begin
        ctl.clear   = opening;
        ctl.seed    = is_add && (single || (valid_pt && !found_base));
        ctl.widen   = is_add && !single && valid_pt && found_base;
        ctl.mid_set = is_add && in_last_reg && !single && (found_base || valid_pt);
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        pcbb_axis #(
            .COORD_BITS(C)
        ) u_axis (
            .coord    (in_coord_reg[a]),
            .low_cur  (low_reg[a]),
            .high_cur (high_reg[a]),
            .mid_cur  (mid_reg[a]),
            .thresh   (thresh_reg),
            .ctl      (ctl),
            .low_next (low_next[a]),
            .high_next(high_next[a]),
            .mid_next (mid_next[a]),
            .in_range (axis_in_range[a]),
            .contained(axis_inside[a])
        );
    end

    always_comb
    begin
        tally_next = opening ? '0 : tally_reg;
        if (ctl.seed)
            tally_next = TW'(1);
        else if (ctl.widen && (tally_reg < TALLY_MAX))
            tally_next = tally_reg + 1'b1;

        found_next = ctl.seed ? !single : found_base;

        ok_next = opening ? 1'b0 : ok_reg;
        if (is_add && in_last_reg && !single)
            ok_next = 1'b1;

        open_next = is_add ? !in_last_reg : open_reg;
    end

    assign tally_ext = 32'(tally_next);

    assign out_data_next = {
        (in_op_reg == OP_QUERY) && (&axis_inside),
        ok_next,
        tally_ext[COUNT_W-1:0],
        mid_next[2], mid_next[1], mid_next[0],
        high_next[2], high_next[1], high_next[0],
        low_next[2], low_next[1], low_next[0]
    };

    // Items without a result may pass a stalled result register
    assign produces = (in_op_reg == OP_QUERY) || in_last_reg;
    assign advance  = in_valid_reg && (!produces || !out_valid_reg || m_tready);
    assign emit     = advance && produces;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg       <= s_tuser;
            in_last_reg     <= s_tlast;
            in_coord_reg[0] <= s_tdata[C-1:0];
            in_coord_reg[1] <= s_tdata[2*C-1:C];
            in_coord_reg[2] <= s_tdata[3*C-1:2*C];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= DIST_RESET;
        else if (cfg_we)
            thresh_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                low_reg[a]  <= {1'b0, {(C-1){1'b1}}};
                high_reg[a] <= {1'b1, {(C-1){1'b0}}};
                mid_reg[a]  <= '0;
            end
            tally_reg <= '0;
            found_reg <= 1'b0;
            open_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else if (advance)
        begin
            for (int a = 0; a < 3; a++)
            begin
                low_reg[a]  <= low_next[a];
                high_reg[a] <= high_next[a];
                mid_reg[a]  <= mid_next[a];
            end
            tally_reg <= tally_next;
            found_reg <= found_next;
            open_reg  <= open_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule

`default_nettype wire

@@ sv/pcbb_axis.sv @@
// One axis of the bounding box datapath: range test, min/max update,
// centre sum and inclusive containment test. Depends on pcbb_pkg.
`default_nettype none

module pcbb_axis
    import pcbb_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input  logic signed [COORD_BITS-1:0] coord,
    input  logic signed [COORD_BITS-1:0] low_cur,
    input  logic signed [COORD_BITS-1:0] high_cur,
    input  logic signed [COORD_BITS:0]   mid_cur,
    input  logic        [THRESH_W-1:0]   thresh,
    input  axis_ctl_t                    ctl,
    output logic signed [COORD_BITS-1:0] low_next,
    output logic signed [COORD_BITS-1:0] high_next,
    output logic signed [COORD_BITS:0]   mid_next,
    output logic                         in_range,
    output logic                         contained
);

    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic        [COORD_BITS-1:0] mag;
    logic signed [COORD_BITS-1:0] low_base;
    logic signed [COORD_BITS-1:0] high_base;

    // Magnitude as unsigned: the most negative value maps to 2^(N-1)
    assign mag       = coord[COORD_BITS-1] ? (~coord + 1'b1) : coord;
    assign in_range  = (33'(mag) <= 33'(thresh));
    assign contained = (coord >= low_cur) && (coord <= high_cur);

    assign low_base  = ctl.clear ? CMAX : low_cur;
    assign high_base = ctl.clear ? CMIN : high_cur;

    always_comb
    begin
        low_next  = low_base;
        high_next = high_base;
        if (ctl.seed)
        begin
            low_next  = coord;
            high_next = coord;
        end
        else if (ctl.widen)
        begin
            if (coord < low_base)
                low_next = coord;
            if (coord > high_base)
                high_next = coord;
        end
    end

    always_comb
    begin
        mid_next = ctl.clear ? '0 : mid_cur;
        if (ctl.mid_set)
            mid_next = {low_next[COORD_BITS-1], low_next}
                     + {high_next[COORD_BITS-1], high_next};
    end

endmodule

`default_nettype wire

@@ sv/pcbb_checker.sv @@
// Port-level checks for point_cloud_bounding_box_top and its bind.
// Depends on pcbb_pkg and the top level's port list.
`default_nettype none

module pcbb_checker
    import pcbb_pkg::*;
#(
    parameter int COORD_BITS = 24
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [((9*COORD_BITS+26+7)/8)*8-1:0] m_tdata
);

    localparam int C = COORD_BITS;

    logic signed [C-1:0] low_x;
    logic signed [C-1:0] low_y;
    logic signed [C-1:0] low_z;
    logic signed [C-1:0] high_x;
    logic signed [C-1:0] high_y;
    logic signed [C-1:0] high_z;
    logic signed [C:0]   mid_x;
    logic [COUNT_W-1:0]  count;
    logic                box_ok;
    logic                inside_res;

    assign low_x      = m_tdata[C-1:0];
    assign low_y      = m_tdata[2*C-1:C];
    assign low_z      = m_tdata[3*C-1:2*C];
    assign high_x     = m_tdata[4*C-1:3*C];
    assign high_y     = m_tdata[5*C-1:4*C];
    assign high_z     = m_tdata[6*C-1:5*C];
    assign mid_x      = m_tdata[7*C:6*C];
    assign count      = m_tdata[9*C+3+COUNT_W-1:9*C+3];
    assign box_ok     = m_tdata[9*C+24];
    assign inside_res = m_tdata[9*C+25];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (count != '0) |->
            (low_x <= high_x) && (low_y <= high_y) && (low_z <= high_z))
        else $error("box with points has minimum above maximum");

    a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && inside_res |-> (count != '0))
        else $error("point reported inside an empty box");

    a_centre: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && box_ok && (count != '0) |->
            (mid_x == ({low_x[C-1], low_x} + {high_x[C-1], high_x})))
        else $error("centre does not match box bounds");

endmodule

bind point_cloud_bounding_box_top pcbb_checker #(
    .COORD_BITS(COORD_BITS)
) u_pcbb_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for point_cloud_bounding_box_top: directed and random point
// clouds and containment queries, checked against an in-bench bounding box predictor.
// Depends on pcbb_pkg and the block's RTL; reads no files.

module tb_top;
    import pcbb_pkg::*;

    localparam int IN_W        = 72;
    localparam int RES_W       = 248;
    localparam int HOLD_CYCLES = 100;
    localparam int LIMIT       = 400000;
    localparam int TALLY_MAX   = 1048576;

    localparam logic signed [23:0] COORD_TOP = 24'sh7FFFFF;
    localparam logic signed [23:0] COORD_BOT = 24'sh800000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               s_tuser;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [RES_W-1:0]   m_tdata;
    logic               cfg_we;
    logic [THRESH_W-1:0] cfg_data;

    // Predicted block state
    logic signed [23:0] box_lo [3];
    logic signed [23:0] box_hi [3];
    logic signed [24:0] box_mid [3];
    int unsigned        pt_count;
    bit                 have_seed;
    bit                 in_cloud;
    bit                 ok_seen;
    logic [THRESH_W-1:0] dist_limit;

    logic [RES_W-1:0]   box_expect [$];
    int                 mismatches = 0;
    int unsigned        cycle_count = 0;
    bit                 no_idle = 1'b0;
    bit                 hold_req = 1'b0;

    typedef struct {
        logic               op;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               last;
        bit                 typed;
        logic [RES_W-1:0]   res;
    } stim_row_t;

    stim_row_t plan [$];

    point_cloud_bounding_box_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("FAIL point_cloud_bounding_box_top");
            $finish;
        end
    end

    function automatic logic [RES_W-1:0] pack_box(
        input logic signed [23:0] lx, ly, lz, hx, hy, hz,
        input logic signed [24:0] mx, my, mz,
        input logic [COUNT_W-1:0] cnt,
        input logic ok,
        input logic ins);
        return {6'd0, ins, ok, cnt, mz, my, mx, hz, hy, hx, lz, ly, lx};
    endfunction

    function automatic logic [RES_W-1:0] current_box(input logic ins);
        return pack_box(box_lo[0], box_lo[1], box_lo[2], box_hi[0], box_hi[1], box_hi[2],
                        box_mid[0], box_mid[1], box_mid[2], COUNT_W'(pt_count), ok_seen, ins);
    endfunction

    function automatic void box_reset();
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a]  = COORD_TOP;
            box_hi[a]  = COORD_BOT;
            box_mid[a] = '0;
        end
        pt_count  = 0;
        have_seed = 1'b0;
        ok_seen   = 1'b0;
    endfunction

    // Advance the predicted state by one accepted transaction; returns 1 when a
    // result is due and puts it in res.
    function automatic bit box_update(input logic op, input logic signed [23:0] px, py, pz,
                                      input logic last, output logic [RES_W-1:0] res);
        logic signed [23:0] p [3];
        longint mag;
        bit pt_ok;
        bit ins;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        res = '0;
        if (op == OP_QUERY)
        begin
            ins = 1'b1;
            for (int a = 0; a < 3; a++)
                if (p[a] < box_lo[a] || p[a] > box_hi[a])
                    ins = 1'b0;
            res = current_box(ins);
            return 1'b1;
        end
        if (!in_cloud)
        begin
            box_reset();
            in_cloud = 1'b1;
            // one-point cloud: store unchecked, centre stays zero
            if (last)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    box_lo[a] = p[a];
                    box_hi[a] = p[a];
                end
                pt_count = 1;
                in_cloud = 1'b0;
                res = current_box(1'b0);
                return 1'b1;
            end
        end
        pt_ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            mag = (p[a] < 0) ? -longint'(p[a]) : longint'(p[a]);
            if (mag > longint'(dist_limit))
                pt_ok = 1'b0;
        end
        if (pt_ok)
        begin
            if (!have_seed)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    box_lo[a] = p[a];
                    box_hi[a] = p[a];
                end
                pt_count  = 1;
                have_seed = 1'b1;
            end
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (p[a] < box_lo[a])
                        box_lo[a] = p[a];
                    if (p[a] > box_hi[a])
                        box_hi[a] = p[a];
                end
                if (pt_count < TALLY_MAX)
                    pt_count++;
            end
        end
        if (!last)
            return 1'b0;
        for (int a = 0; a < 3; a++)
            box_mid[a] = have_seed ? {box_lo[a][23], box_lo[a]} + {box_hi[a][23], box_hi[a]}
                                   : 25'd0;
        ok_seen  = 1'b1;
        in_cloud = 1'b0;
        res = current_box(1'b0);
        return 1'b1;
    endfunction

    function automatic logic [63:0] res_field(input logic [RES_W-1:0] v, input int i,
                                              output string nm);
        case (i)
            0:       begin nm = "low_x";       return v[23:0];    end
            1:       begin nm = "low_y";       return v[47:24];   end
            2:       begin nm = "low_z";       return v[71:48];   end
            3:       begin nm = "high_x";      return v[95:72];   end
            4:       begin nm = "high_y";      return v[119:96];  end
            5:       begin nm = "high_z";      return v[143:120]; end
            6:       begin nm = "mid_x";       return v[168:144]; end
            7:       begin nm = "mid_y";       return v[193:169]; end
            8:       begin nm = "mid_z";       return v[218:194]; end
            9:       begin nm = "valid_count"; return v[239:219]; end
            10:      begin nm = "box_ok";      return v[240];     end
            default: begin nm = "inside_res";  return v[241];     end
        endcase
    endfunction

    always @(posedge clk)
    begin : result_check
        logic [RES_W-1:0] want;
        logic [63:0] fw;
        logic [63:0] fg;
        string nm;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (box_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %0h", m_tdata);
            end
            else
            begin
                want = box_expect.pop_front();
                for (int i = 0; i < 12; i++)
                begin
                    fw = res_field(want, i, nm);
                    fg = res_field(m_tdata, i, nm);
                    if (fg !== fw)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch on %s: expected %0h got %0h", nm, fw, fg);
                    end
                end
            end
        end
    end

    // Result side: random stall bursts, a long hold-off on request, steady when told
    initial
    begin : result_sink
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    function automatic logic signed [23:0] pick_coord();
        longint t;
        longint v;
        t = longint'(dist_limit);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 24'(longint'($urandom_range(0, 32'(2 * t))) - t);
            4:
            begin
                v = t + longint'($urandom_range(0, 1));
                return 24'($urandom_range(0, 1) ? v : -v);
            end
            5:       return $urandom_range(0, 1) ? COORD_TOP : COORD_BOT;
            6, 7:    return 24'($urandom());
            default: return 24'(longint'($urandom_range(0, 2)) - 1);
        endcase
    endfunction

    task automatic drive_item(input logic op, input logic signed [23:0] x, y, z,
                              input logic last, input bit typed,
                              input logic [RES_W-1:0] typed_res);
        logic [RES_W-1:0] res;
        bit has_res;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= op;
        s_tlast  <= last;
        do @(posedge clk); while (s_tready !== 1'b1);
        has_res = box_update(op, x, y, z, last, res);
        if (has_res)
            box_expect.push_back(typed ? typed_res : res);
    endtask

    // Query mostly on and just beyond the bounds held now
    task automatic send_query();
        logic signed [23:0] q [3];
        longint lo;
        longint hi;
        for (int a = 0; a < 3; a++)
        begin
            lo = box_lo[a];
            hi = box_hi[a];
            case ($urandom_range(0, 5))
                0:       q[a] = box_lo[a];
                1:       q[a] = box_hi[a];
                2:       q[a] = 24'(lo - 1);
                3:       q[a] = 24'(hi + 1);
                4:       q[a] = (lo <= hi) ? 24'(lo + $urandom_range(0, 32'(hi - lo)))
                                           : pick_coord();
                default: q[a] = pick_coord();
            endcase
        end
        drive_item(OP_QUERY, q[0], q[1], q[2], 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (box_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [THRESH_W-1:0] v);
        wait_drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        dist_limit = v;
    endtask

    task automatic run_phase(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                send_query();
                sent++;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       len = 1;
                    1:       len = $urandom_range(20, 60);
                    default: len = $urandom_range(2, 8);
                endcase
                for (int k = 0; k < len; k++)
                begin
                    // query against a partly built box now and then
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_query();
                        sent++;
                    end
                    drive_item(OP_ADD, pick_coord(), pick_coord(), pick_coord(),
                               k == len - 1, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    function automatic void add_row(input logic op, input logic signed [23:0] x, y, z,
                                    input logic last, input bit typed,
                                    input logic [RES_W-1:0] res);
        stim_row_t r;
        r.op    = op;
        r.x     = x;
        r.y     = y;
        r.z     = z;
        r.last  = last;
        r.typed = typed;
        r.res   = res;
        plan.push_back(r);
    endfunction

    initial
    begin : stimulus
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_ADD;
        s_tlast  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= DIST_RESET;
        box_reset();
        in_cloud   = 1'b0;
        dist_limit = DIST_RESET;

        // empty box after reset contains nothing
        add_row(OP_QUERY, 0, 0, 0, 1'b0, 1'b1,
                pack_box(COORD_TOP, COORD_TOP, COORD_TOP, COORD_BOT, COORD_BOT, COORD_BOT,
                         0, 0, 0, 0, 1'b0, 1'b0));
        // one-point cloud at the most negative corner is stored unchecked
        add_row(OP_ADD, COORD_BOT, COORD_BOT, COORD_BOT, 1'b1, 1'b1,
                pack_box(COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT,
                         0, 0, 0, 1, 1'b0, 1'b0));
        add_row(OP_QUERY, COORD_BOT, COORD_BOT, COORD_BOT, 1'b0, 1'b1,
                pack_box(COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT,
                         0, 0, 0, 1, 1'b0, 1'b1));
        add_row(OP_QUERY, COORD_TOP, COORD_BOT, COORD_BOT, 1'b1, 1'b1,
                pack_box(COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT,
                         0, 0, 0, 1, 1'b0, 1'b0));
        // two points exactly on the threshold
        add_row(OP_ADD, 90000, -90000, 0, 1'b0, 1'b0, '0);
        add_row(OP_QUERY, 0, 0, 0, 1'b0, 1'b0, '0);
        add_row(OP_ADD, -90000, 90000, 1, 1'b1, 1'b1,
                pack_box(-90000, -90000, 0, 90000, 90000, 1, 0, 0, 1, 2, 1'b1, 1'b0));
        add_row(OP_QUERY, 90000, 90000, 1, 1'b0, 1'b1,
                pack_box(-90000, -90000, 0, 90000, 90000, 1, 0, 0, 1, 2, 1'b1, 1'b1));
        add_row(OP_QUERY, -90001, 0, 0, 1'b0, 1'b0, '0);
        // longer cloud with no valid point keeps the empty extremes
        add_row(OP_ADD, 90001, 0, 0, 1'b0, 1'b0, '0);
        add_row(OP_ADD, 0, 0, -90001, 1'b0, 1'b0, '0);
        add_row(OP_ADD, COORD_TOP, COORD_TOP, COORD_TOP, 1'b0, 1'b0, '0);
        add_row(OP_ADD, COORD_BOT, 0, 0, 1'b1, 1'b1,
                pack_box(COORD_TOP, COORD_TOP, COORD_TOP, COORD_BOT, COORD_BOT, COORD_BOT,
                         0, 0, 0, 0, 1'b1, 1'b0));
        add_row(OP_QUERY, 0, 0, 0, 1'b0, 1'b1,
                pack_box(COORD_TOP, COORD_TOP, COORD_TOP, COORD_BOT, COORD_BOT, COORD_BOT,
                         0, 0, 0, 0, 1'b1, 1'b0));
        // invalid first point, then valid ones seed and widen
        add_row(OP_ADD, 100000, 0, 0, 1'b0, 1'b0, '0);
        add_row(OP_ADD, 5, -7, 3, 1'b0, 1'b0, '0);
        add_row(OP_ADD, -90000, 90000, -90000, 1'b0, 1'b0, '0);
        add_row(OP_ADD, 12, 0, 90000, 1'b1, 1'b0, '0);
        add_row(OP_ADD, COORD_TOP, 0, -1, 1'b1, 1'b1,
                pack_box(COORD_TOP, 0, -1, COORD_TOP, 0, -1, 0, 0, 0, 1, 1'b0, 1'b0));
        add_row(OP_QUERY, COORD_TOP, 0, -1, 1'b0, 1'b0, '0);
        add_row(OP_ADD, -1, -1, -1, 1'b0, 1'b0, '0);
        add_row(OP_ADD, -1, -1, -1, 1'b1, 1'b0, '0);
        add_row(OP_QUERY, -1, -1, -1, 1'b1, 1'b0, '0);
        add_row(OP_QUERY, -1, -1, 0, 1'b0, 1'b0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            drive_item(plan[i].op, plan[i].x, plan[i].y, plan[i].z, plan[i].last,
                       plan[i].typed, plan[i].res);

        set_threshold('0);
        run_phase(200);

        set_threshold({THRESH_W{1'b1}});
        // hold the result side off while queries keep coming, so the block stalls
        hold_req = 1'b1;
        while (m_tready)
            @(posedge clk);
        repeat (40) send_query();
        wait_drain();
        run_phase(200);

        set_threshold(1);
        run_phase(150);

        set_threshold(THRESH_W'($urandom_range(0, 8388607)));
        run_phase(200);

        set_threshold(THRESH_W'($urandom_range(2, 300)));
        run_phase(200);

        no_idle = 1'b1;
        set_threshold(DIST_RESET);
        run_phase(200);

        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && box_expect.size() == 0)
            $display("PASS point_cloud_bounding_box_top");
        else
            $display("FAIL point_cloud_bounding_box_top");
        $finish;
    end

endmodule
